// File: rtl/core/sgps_pkg.sv
// ----------------------------------------------------------------------------
// sgps_pkg
// Shared constants and types of the five-point quadratic path smoother.
// ----------------------------------------------------------------------------
`default_nettype none

package sgps_pkg;

    // default coordinate width, signed two's complement
    localparam int SGPS_COORD_BITS = 16;

    // kernel (-3, 12, 17, 12, -3) / 35
    localparam int W_OUTER    = 3;
    localparam int W_NEAR     = 12;
    localparam int W_CENTER   = 17;
    localparam int DIVISOR    = 35;
    localparam int ROUND_BIAS = 17;

    // |weighted sum| + bias stays below 2^(COORD_BITS + EXTRA_BITS)
    localparam int EXTRA_BITS = 5;

    localparam int FULL_WINDOW = 4;
    localparam int MIN_HISTORY = 2;
    localparam int SEEN_BITS   = 3;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_DRAIN_PREV,
        ST_DRAIN_LAST
    } t_state;

    // control that travels along the divider chain next to the data
    typedef struct packed {
        logic vld;
        logic last;
        logic neg_x;
        logic neg_y;
    } t_div_ctl;

endpackage

`default_nettype wire

// File: rtl/core/sgps_in_if.sv
// ----------------------------------------------------------------------------
// sgps_in_if
// Point request channel: valid/ready with x, y and a last-of-path mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface sgps_in_if import sgps_pkg::*; #(
    parameter int COORD_BITS = SGPS_COORD_BITS
) ();

    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] in_x;
    logic signed [COORD_BITS-1:0] in_y;
    logic                         in_last;

    modport source (output valid, output in_x, output in_y, output in_last, input ready);
    modport sink   (input valid, input in_x, input in_y, input in_last, output ready);

endinterface

`default_nettype wire

// File: rtl/core/sgps_out_if.sv
// ----------------------------------------------------------------------------
// sgps_out_if
// Result request channel: valid/ready with x, y and a last-of-path mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface sgps_out_if import sgps_pkg::*; #(
    parameter int COORD_BITS = SGPS_COORD_BITS
) ();

    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic                         out_last;

    modport source (output valid, output out_x, output out_y, output out_last, input ready);
    modport sink   (input valid, input out_x, input out_y, input out_last, output ready);

endinterface

`default_nettype wire

// File: rtl/core/sgps_tap_cell.sv
// ----------------------------------------------------------------------------
// sgps_tap_cell
// One point of the history window; hands its point to the next cell on shift.
// ----------------------------------------------------------------------------
`default_nettype none

module sgps_tap_cell import sgps_pkg::*; #(
    parameter int COORD_BITS = SGPS_COORD_BITS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_shift,
    input  wire logic signed [COORD_BITS-1:0] i_x,
    input  wire logic signed [COORD_BITS-1:0] i_y,
    output logic signed [COORD_BITS-1:0]      o_x,
    output logic signed [COORD_BITS-1:0]      o_y
);

    logic signed [COORD_BITS-1:0] r_x;
    logic signed [COORD_BITS-1:0] r_y;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_x <= i_x;
            r_y <= i_y;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;

endmodule

`default_nettype wire

// File: rtl/core/sgps_div_cell.sv
// ----------------------------------------------------------------------------
// sgps_div_cell
// Divide by 35 for x and y by reciprocal multiplication, with its pipeline slot.
// ----------------------------------------------------------------------------
`default_nettype none

module sgps_div_cell import sgps_pkg::*; #(
    parameter int COORD_BITS = SGPS_COORD_BITS
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire t_div_ctl                             i_ctl,
    input  wire logic [COORD_BITS+EXTRA_BITS-1:0]     i_num_x,
    input  wire logic [COORD_BITS+EXTRA_BITS-1:0]     i_num_y,
    input  wire logic                                 i_ready,
    output logic                                      o_ready,
    output t_div_ctl                                  o_ctl,
    output logic [COORD_BITS-1:0]                     o_q_x,
    output logic [COORD_BITS-1:0]                     o_q_y
);

    localparam int RW = COORD_BITS + EXTRA_BITS;
    // floor(n * K / 2^SH) equals floor(n / 35) for every n below 2^RW
    localparam int SH = RW + 6;
    localparam int KW = SH - 5;
    localparam int PW = RW + KW;
    localparam logic [KW-1:0] L_RECIP =
        KW'(((longint'(1) << SH) + longint'(DIVISOR) - longint'(1)) / longint'(DIVISOR));

    t_div_ctl              r_ctl;
    logic [COORD_BITS-1:0] r_q_x;
    logic [COORD_BITS-1:0] r_q_y;
    logic [PW-1:0]         w_prod_x;
    logic [PW-1:0]         w_prod_y;

    assign o_ready  = !r_ctl.vld || i_ready;
    assign w_prod_x = PW'(i_num_x) * PW'(L_RECIP);
    assign w_prod_y = PW'(i_num_y) * PW'(L_RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (o_ready) begin
            r_ctl <= i_ctl;
        end
    end

    // quotient stays below 2^COORD_BITS, so the top bits are all of it
    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_q_x <= w_prod_x[PW-1:SH];
            r_q_y <= w_prod_y[PW-1:SH];
        end
    end

    assign o_ctl = r_ctl;
    assign o_q_x = r_q_x;
    assign o_q_y = r_q_y;

endmodule

`default_nettype wire

// File: rtl/core/savitzky_golay_path_smoother.sv
// ----------------------------------------------------------------------------
// savitzky_golay_path_smoother
// Five-point quadratic smoothing of a stream of 2-D path points.
// ----------------------------------------------------------------------------
// Points come in on i_pt (valid/ready, x, y, last) and results leave on o_pt.
// Every point is replaced by (-3,12,17,12,-3)/35 over its neighbors, rounded
// to nearest (ties away from zero) and saturated; the first two and last two
// points of a path, and all points of paths shorter than five, pass through.
// Results lag the input by two points. A point marked last flushes the rest
// of the path (up to three results, the final one marked last); i_pt.ready
// drops while that flush issues its extra results, otherwise one point
// is taken every cycle while the pipeline is not stalled.
// An accepted request passes the sum stage, the magnitude stage, the
// reciprocal multiply for the divide by 35 and the output register, in order.
// Throughput is one result per cycle while o_pt.ready stays high.
// Every stage holds its request while the next one is stalled, so a stall on
// o_pt fills the pipeline before i_pt.ready falls; empty slots are closed up.
// Reset (synchronous, active low) empties the pipeline and starts a new path;
// the window contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module savitzky_golay_path_smoother import sgps_pkg::*; #(
    parameter int COORD_BITS = SGPS_COORD_BITS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sgps_in_if.sink    i_pt,
    sgps_out_if.source o_pt
);

    localparam int SW = COORD_BITS + EXTRA_BITS + 1;
    localparam int RW = COORD_BITS + EXTRA_BITS;
    localparam int NCELL = FULL_WINDOW;

    localparam logic [COORD_BITS-1:0] L_HI = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic [COORD_BITS-1:0] L_LO = {1'b1, {(COORD_BITS-1){1'b0}}};

    // ---------------- front end: window and flush sequencer ----------------
    t_state                r_state;
    t_state                n_state;
    logic [SEEN_BITS-1:0]  r_seen;
    logic [SEEN_BITS-1:0]  n_seen;

    logic                  w_in_fire;
    logic                  w_rdy_s0;
    logic                  w_emit_vld;
    logic                  w_emit_smooth;
    logic                  w_emit_last;
    logic                  w_emit_tap0;
    logic                  w_in_ready;

    logic signed [COORD_BITS-1:0] w_tap_x [0:NCELL];
    logic signed [COORD_BITS-1:0] w_tap_y [0:NCELL];

    assign w_tap_x[0] = i_pt.in_x;
    assign w_tap_y[0] = i_pt.in_y;

    genvar gt;
    generate
        for (gt = 0; gt < NCELL; gt++) begin : g_tap
            sgps_tap_cell #(
                .COORD_BITS (COORD_BITS)
            ) u_tap (
                .i_clk   (i_clk),
                .i_shift (w_in_fire),
                .i_x     (w_tap_x[gt]),
                .i_y     (w_tap_y[gt]),
                .o_x     (w_tap_x[gt+1]),
                .o_y     (w_tap_y[gt+1])
            );
        end
    endgenerate

    assign w_in_fire = i_pt.valid && w_in_ready;
    assign i_pt.ready = w_in_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_RUN: begin
                if (w_in_fire && i_pt.in_last) begin
                    n_state = (r_seen != '0) ? ST_DRAIN_PREV : ST_DRAIN_LAST;
                end
            end
            ST_DRAIN_PREV: begin
                if (w_rdy_s0) begin
                    n_state = ST_DRAIN_LAST;
                end
            end
            ST_DRAIN_LAST: begin
                if (w_rdy_s0) begin
                    n_state = ST_RUN;
                end
            end
            default: n_state = ST_RUN;
        endcase
    end

    // the last point is shifted in like any other, so the flush reads taps
    always_comb begin
        w_in_ready    = 1'b0;
        w_emit_vld    = 1'b0;
        w_emit_smooth = 1'b0;
        w_emit_last   = 1'b0;
        w_emit_tap0   = 1'b0;
        unique case (r_state)
            ST_RUN: begin
                w_in_ready    = w_rdy_s0;
                w_emit_vld    = w_in_fire && (r_seen >= SEEN_BITS'(MIN_HISTORY));
                w_emit_smooth = r_seen >= SEEN_BITS'(FULL_WINDOW);
            end
            ST_DRAIN_PREV: begin
                w_emit_vld = 1'b1;
            end
            ST_DRAIN_LAST: begin
                w_emit_vld  = 1'b1;
                w_emit_last = 1'b1;
                w_emit_tap0 = 1'b1;
            end
            default: begin
                w_emit_vld = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_seen = r_seen;
        if (w_in_fire) begin
            if (i_pt.in_last) begin
                n_seen = '0;
            end else if (r_seen < SEEN_BITS'(FULL_WINDOW)) begin
                n_seen = r_seen + SEEN_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
            r_seen  <= '0;
        end else begin
            r_state <= n_state;
            r_seen  <= n_seen;
        end
    end

    // ---------------- sum stage ----------------
    logic signed [SW-1:0] w_sum_x;
    logic signed [SW-1:0] w_sum_y;
    logic signed [SW-1:0] w_pass_x;
    logic signed [SW-1:0] w_pass_y;

    // taps: newest is the current input, then window cells 0..3
    assign w_sum_x = SW'(W_NEAR) * (SW'(w_tap_x[3]) + SW'(w_tap_x[1]))
                   + SW'(W_CENTER) * SW'(w_tap_x[2])
                   - SW'(W_OUTER) * (SW'(w_tap_x[4]) + SW'(w_tap_x[0]));
    assign w_sum_y = SW'(W_NEAR) * (SW'(w_tap_y[3]) + SW'(w_tap_y[1]))
                   + SW'(W_CENTER) * SW'(w_tap_y[2])
                   - SW'(W_OUTER) * (SW'(w_tap_y[4]) + SW'(w_tap_y[0]));

    // pass-through goes through the divider as 35 * point
    assign w_pass_x = SW'(DIVISOR) * (w_emit_tap0 ? SW'(w_tap_x[1]) : SW'(w_tap_x[2]));
    assign w_pass_y = SW'(DIVISOR) * (w_emit_tap0 ? SW'(w_tap_y[1]) : SW'(w_tap_y[2]));

    logic                 r_s0_vld;
    logic                 r_s0_last;
    logic signed [SW-1:0] r_s0_x;
    logic signed [SW-1:0] r_s0_y;
    logic                 w_rdy_s1;

    assign w_rdy_s0 = !r_s0_vld || w_rdy_s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (w_rdy_s0) begin
            r_s0_vld <= w_emit_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_s0) begin
            r_s0_last <= w_emit_last;
            r_s0_x    <= w_emit_smooth ? w_sum_x : w_pass_x;
            r_s0_y    <= w_emit_smooth ? w_sum_y : w_pass_y;
        end
    end

    // ---------------- magnitude stage ----------------
    logic [SW-1:0]         w_abs_x;
    logic [SW-1:0]         w_abs_y;
    t_div_ctl              r_s1_ctl;
    logic [RW-1:0]         r_s1_rem_x;
    logic [RW-1:0]         r_s1_rem_y;
    logic                  w_rdy_div;

    assign w_abs_x  = r_s0_x[SW-1] ? SW'(-r_s0_x) : SW'(r_s0_x);
    assign w_abs_y  = r_s0_y[SW-1] ? SW'(-r_s0_y) : SW'(r_s0_y);
    assign w_rdy_s1 = !r_s1_ctl.vld || w_rdy_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
        end else if (w_rdy_s1) begin
            r_s1_ctl.vld   <= r_s0_vld;
            r_s1_ctl.last  <= r_s0_last;
            r_s1_ctl.neg_x <= r_s0_x[SW-1];
            r_s1_ctl.neg_y <= r_s0_y[SW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_s1) begin
            r_s1_rem_x <= w_abs_x[RW-1:0] + RW'(ROUND_BIAS);
            r_s1_rem_y <= w_abs_y[RW-1:0] + RW'(ROUND_BIAS);
        end
    end

    // ---------------- divide by 35 ----------------
    logic                  w_rdy_out;
    t_div_ctl              w_div_ctl;
    logic [COORD_BITS-1:0] w_qx;
    logic [COORD_BITS-1:0] w_qy;

    sgps_div_cell #(
        .COORD_BITS (COORD_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_s1_ctl),
        .i_num_x (r_s1_rem_x),
        .i_num_y (r_s1_rem_y),
        .i_ready (w_rdy_out),
        .o_ready (w_rdy_div),
        .o_ctl   (w_div_ctl),
        .o_q_x   (w_qx),
        .o_q_y   (w_qy)
    );

    // ---------------- sign, saturation and output register ----------------
    logic                  r_out_vld;
    logic                  r_out_last;
    logic [COORD_BITS-1:0] r_out_x;
    logic [COORD_BITS-1:0] r_out_y;
    logic [COORD_BITS-1:0] w_fin_x;
    logic [COORD_BITS-1:0] w_fin_y;

    always_comb begin
        if (!w_div_ctl.neg_x) begin
            w_fin_x = w_qx[COORD_BITS-1] ? L_HI : w_qx;
        end else begin
            w_fin_x = (w_qx[COORD_BITS-1] && (|w_qx[COORD_BITS-2:0])) ? L_LO
                                                                       : (~w_qx + COORD_BITS'(1));
        end
        if (!w_div_ctl.neg_y) begin
            w_fin_y = w_qy[COORD_BITS-1] ? L_HI : w_qy;
        end else begin
            w_fin_y = (w_qy[COORD_BITS-1] && (|w_qy[COORD_BITS-2:0])) ? L_LO
                                                                       : (~w_qy + COORD_BITS'(1));
        end
    end

    assign w_rdy_out = !r_out_vld || o_pt.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_rdy_out) begin
            r_out_vld <= w_div_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_out) begin
            r_out_last <= w_div_ctl.last;
            r_out_x    <= w_fin_x;
            r_out_y    <= w_fin_y;
        end
    end

    assign o_pt.valid    = r_out_vld;
    assign o_pt.out_last = r_out_last;
    assign o_pt.out_x    = $signed(r_out_x);
    assign o_pt.out_y    = $signed(r_out_y);

    // ---------------- checks ----------------
    a_seen_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= SEEN_BITS'(FULL_WINDOW))
        else $error("point count ran past the window");

    a_last_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire && i_pt.in_last |=> (r_state != ST_RUN) && (r_seen == '0))
        else $error("last point did not start a flush");

    a_flush_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN_LAST) && w_rdy_s0 |=> r_s0_vld && r_s0_last && (r_state == ST_RUN))
        else $error("flush did not issue the final point");

    a_no_take_in_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_RUN) |-> !w_in_fire && w_emit_vld)
        else $error("input taken or flush idle during flush");

endmodule

`default_nettype wire
